// ===== rtl/aws_pkg.sv =====
// Shared types and constants for the altitude window statistics block.
// Depends on nothing; the core and checker rtl files refer to it by scoped names.
`default_nettype none

package aws_pkg;

  // Default configuration
  localparam int WINDOW_MAX_DEFAULT    = 64;
  localparam int ALTITUDE_BITS_DEFAULT = 20;
  localparam int WINDOW_RESET          = 60;
  localparam logic [15:0] HYST_RESET   = 16'd1000;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int WIN_REG_BITS  = 7;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS    = 2'd1;

  // Climb arithmetic width: signed delta, magnitude up to 2^32, plus carry
  localparam int CLIMB_BITS = 34;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CLIMB,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/aws_divider.sv =====
// Restoring bit-serial divider: one quotient bit per cycle, unsigned operands.
// Depends on nothing outside this file.
`default_nettype none

module aws_divider #(
  parameter int DIVIDEND_BITS = 26,
  parameter int DIVISOR_BITS  = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [DIVISOR_BITS-1:0]  divisor,
  output logic                          done,
  output logic [DIVIDEND_BITS-1:0]      quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quot_r, quot_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0]  dvs_r, dvs_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem_r, quot_r[DIVIDEND_BITS-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  // Load on start, then shift one bit per cycle
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_BITS'(DIVIDEND_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[DIVIDEND_BITS-2:0], fits};
      rem_nxt  = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

// ===== rtl/altitude_window_statistics_core.sv =====
// Altitude window statistics: moving average, min/max, hysteresis climb.
// Each item passes a sum update, a climb update, the divider (one quotient bit per sum bit,
// ALTITUDE_BITS + log2(WINDOW_MAX) = 26 by default) and an output load.
// A new item is taken only once the last result is loaded; a stalled result holds it off.
// Synchronous active-low reset clears all statistics and restores the registers.
// Depends on aws_pkg and aws_divider.
`default_nettype none

module altitude_window_statistics_core #(
  parameter int WINDOW_MAX    = aws_pkg::WINDOW_MAX_DEFAULT,
  parameter int ALTITUDE_BITS = aws_pkg::ALTITUDE_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [aws_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [aws_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // input item
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [ALTITUDE_BITS-1:0]   in_altitude,
  // result item
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [ALTITUDE_BITS-1:0]        out_average,
  output logic signed [ALTITUDE_BITS-1:0]        out_minimum,
  output logic signed [ALTITUDE_BITS-1:0]        out_maximum,
  output logic [31:0]                            out_ascent,
  output logic [31:0]                            out_descent
);

  localparam int AB  = ALTITUDE_BITS;
  localparam int PW  = $clog2(WINDOW_MAX);
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int SW  = AB + PW;
  localparam int CFW = (CW > aws_pkg::WIN_REG_BITS) ? CW : aws_pkg::WIN_REG_BITS;
  localparam int EW  = aws_pkg::CLIMB_BITS;
  localparam int LEN_RESET =
    (aws_pkg::WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : aws_pkg::WINDOW_RESET;

  aws_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]          len_r;
  logic [15:0]            hyst_r;
  logic [AB-1:0]          x_r;
  logic [AB-1:0]          ring [WINDOW_MAX];
  logic [AB-1:0]          rd_data_r;
  logic [PW-1:0]          wptr_r, wptr_nxt;
  logic [CW-1:0]          held_r, held_nxt;
  logic [SW-1:0]          sum_r, sum_nxt;
  logic [AB-1:0]          low_r, low_nxt;
  logic [AB-1:0]          high_r, high_nxt;
  logic [AB-1:0]          ref_r, ref_nxt;
  logic [31:0]            climb_r, climb_nxt;
  logic [31:0]            drop_r, drop_nxt;
  logic                   seen_r;
  logic                   out_valid_r;
  logic [AB-1:0]          avg_r, min_r, max_r;
  logic [31:0]            asc_r, desc_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   sum_en, climb_en, div_start, out_load;
  logic [CFW-1:0]         win_wr;
  logic [SW-1:0]          x_ext, old_ext;
  logic                   full;
  logic [EW-1:0]          delta, neg_delta, hyst_ext, up_sum, dn_sum;
  logic [AB-1:0]          ref_eff;
  logic [SW-1:0]          sum_mag;
  logic                   sum_neg_r;
  logic                   div_done;
  logic [SW-1:0]          div_quot;
  logic [SW-1:0]          avg_full;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration registers; window length locks after the first item
  assign win_wr = CFW'(cfg_data[aws_pkg::WIN_REG_BITS-1:0]);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= CW'(LEN_RESET);
      hyst_r <= aws_pkg::HYST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aws_pkg::REG_WINDOW_LENGTH: begin
          if (!seen_r) begin
            if (win_wr == '0) begin
              len_r <= CW'(1);
            end else if (win_wr > CFW'(WINDOW_MAX)) begin
              len_r <= CW'(WINDOW_MAX);
            end else begin
              len_r <= CW'(win_wr);
            end
          end
        end
        aws_pkg::REG_HYSTERESIS: hyst_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aws_pkg::ST_IDLE:  if (in_valid) state_nxt = aws_pkg::ST_SUM;
      aws_pkg::ST_SUM:   state_nxt = aws_pkg::ST_CLIMB;
      aws_pkg::ST_CLIMB: state_nxt = aws_pkg::ST_DIV;
      aws_pkg::ST_DIV:   if (div_done) state_nxt = aws_pkg::ST_OUT;
      aws_pkg::ST_OUT:   if (out_free) state_nxt = aws_pkg::ST_IDLE;
      default:           state_nxt = aws_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    sum_en    = 1'b0;
    climb_en  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      aws_pkg::ST_IDLE:  in_stall = 1'b0;
      aws_pkg::ST_SUM:   sum_en = 1'b1;
      aws_pkg::ST_CLIMB: begin
        climb_en  = 1'b1;
        div_start = 1'b1;
      end
      aws_pkg::ST_DIV:   ;
      aws_pkg::ST_OUT:   out_load = out_free;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r <= in_altitude;
    end
  end

  // Ring store: registered read at the write pointer, write during sum update
  always_ff @(posedge clk) begin
    if (sum_en) begin
      ring[wptr_r] <= x_r;
    end
    rd_data_r <= ring[wptr_r];
  end

  // Running sum, fill count, pointer, min and max
  always_comb begin
    full     = (held_r >= len_r);
    x_ext    = {{(SW-AB){x_r[AB-1]}}, x_r};
    old_ext  = {{(SW-AB){rd_data_r[AB-1]}}, rd_data_r};
    sum_nxt  = full ? (sum_r - old_ext + x_ext) : (sum_r + x_ext);
    held_nxt = full ? len_r : (held_r + 1'b1);
    wptr_nxt = ((CW'(wptr_r) + 1'b1) >= len_r) ? '0 : (wptr_r + 1'b1);
    low_nxt  = (!seen_r || ($signed(x_r) < $signed(low_r))) ? x_r : low_r;
    high_nxt = (!seen_r || ($signed(x_r) > $signed(high_r))) ? x_r : high_r;
  end

  // Climb and drop against the reference with hysteresis
  always_comb begin
    ref_eff   = seen_r ? ref_r : x_r;
    delta     = {{(EW-AB){x_r[AB-1]}}, x_r} - {{(EW-AB){ref_eff[AB-1]}}, ref_eff};
    neg_delta = '0 - delta;
    hyst_ext  = EW'(hyst_r);
    up_sum    = EW'(climb_r) + delta;
    dn_sum    = EW'(drop_r) + neg_delta;
    climb_nxt = climb_r;
    drop_nxt  = drop_r;
    ref_nxt   = ref_eff;
    if ($signed(delta) > $signed(hyst_ext)) begin
      climb_nxt = (up_sum[EW-1:32] != '0) ? 32'hFFFF_FFFF : up_sum[31:0];
      ref_nxt   = x_r;
    end else if ($signed(neg_delta) > $signed(hyst_ext)) begin
      drop_nxt = (dn_sum[EW-1:32] != '0) ? 32'hFFFF_FFFF : dn_sum[31:0];
      ref_nxt  = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      held_r  <= '0;
      sum_r   <= '0;
      low_r   <= '0;
      high_r  <= '0;
      ref_r   <= '0;
      climb_r <= '0;
      drop_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      if (sum_en) begin
        wptr_r <= wptr_nxt;
        held_r <= held_nxt;
        sum_r  <= sum_nxt;
        low_r  <= low_nxt;
        high_r <= high_nxt;
      end
      if (climb_en) begin
        ref_r   <= ref_nxt;
        climb_r <= climb_nxt;
        drop_r  <= drop_nxt;
        seen_r  <= 1'b1;
      end
    end
  end

  // Divide the sum magnitude by the fill count
  assign sum_mag = sum_r[SW-1] ? ('0 - sum_r) : sum_r;

  always_ff @(posedge clk) begin
    if (div_start) begin
      sum_neg_r <= sum_r[SW-1];
    end
  end

  aws_divider #(
    .DIVIDEND_BITS (SW),
    .DIVISOR_BITS  (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (held_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Restore the sign of the quotient
  assign avg_full = sum_neg_r ? ('0 - div_quot) : div_quot;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_r  <= avg_full[AB-1:0];
      min_r  <= low_r;
      max_r  <= high_r;
      asc_r  <= climb_r;
      desc_r <= drop_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = avg_r;
  assign out_minimum = min_r;
  assign out_maximum = max_r;
  assign out_ascent  = asc_r;
  assign out_descent = desc_r;

endmodule

`default_nettype wire

// ===== rtl/aws_checker.sv =====
// Port-level checks for altitude_window_statistics_core, bound to the top level.
// Depends on aws_pkg for port widths.
`default_nettype none

module aws_checker #(
  parameter int ALTITUDE_BITS = aws_pkg::ALTITUDE_BITS_DEFAULT
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [ALTITUDE_BITS-1:0]   out_average,
  input wire logic signed [ALTITUDE_BITS-1:0]   out_minimum,
  input wire logic signed [ALTITUDE_BITS-1:0]   out_maximum,
  input wire logic [31:0]                       out_ascent,
  input wire logic [31:0]                       out_descent
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // A new result only appears while an item is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  // Running minimum never exceeds running maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minimum <= out_maximum))
    else $error("minimum above maximum");

  // Stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_average)
      && $stable(out_minimum) && $stable(out_maximum)
      && $stable(out_ascent) && $stable(out_descent)))
    else $error("stalled result changed");

endmodule

bind altitude_window_statistics_core aws_checker #(
  .ALTITUDE_BITS (ALTITUDE_BITS)
) u_aws_checker (.*);

`default_nettype wire

// ===== dv/altitude_window_statistics_core_test.sv =====
// Self-checking bench for altitude_window_statistics_core: altitude samples in, statistics out.
// A class tracks the expected moving average, min/max and hysteresis climb per accepted item.
// Depends on aws_pkg and the block's RTL only.
`default_nettype none

module altitude_window_statistics_core_test;

  localparam int AW      = aws_pkg::ALTITUDE_BITS_DEFAULT;
  localparam int WIN_MAX = aws_pkg::WINDOW_MAX_DEFAULT;

  // Indexes past the register list; writes there must change nothing
  localparam logic [aws_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [aws_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  localparam longint ALT_TOP    = (64'sd1 <<< (AW - 1)) - 1;
  localparam longint ALT_BOTTOM = -(64'sd1 <<< (AW - 1));
  localparam longint unsigned ACC_MAX = 64'hFFFF_FFFF;

  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 750;
  localparam int SWING_ITEMS   = 32;
  localparam int LIMIT_CYCLES  = 3000000;
  localparam int REPORT_CAP    = 50;

  typedef struct {
    logic signed [AW-1:0] average;
    logic signed [AW-1:0] minimum;
    logic signed [AW-1:0] maximum;
    logic [31:0]          ascent;
    logic [31:0]          descent;
  } stats_t;

  // Expected statistics, kept item by item from the accepted samples
  class stats_tracker;
    int     window_len;
    longint hysteresis;
    longint ring [WIN_MAX];
    int     wr_ptr;
    int     held;
    longint sum;
    longint lowest;
    longint highest;
    longint reference;
    longint unsigned ascent_total;
    longint unsigned descent_total;
    bit     started;
    stats_t pending [$];
    int     errors;
    int     reports;

    function new();
      window_len    = aws_pkg::WINDOW_RESET;
      hysteresis    = aws_pkg::HYST_RESET;
      wr_ptr        = 0;
      held          = 0;
      sum           = 0;
      lowest        = 0;
      highest       = 0;
      reference     = 0;
      ascent_total  = 0;
      descent_total = 0;
      started       = 1'b0;
      errors        = 0;
      reports       = 0;
    endfunction

    function void apply_register(logic [aws_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [aws_pkg::CFG_DATA_BITS-1:0] data);
      int w;
      w = data[aws_pkg::WIN_REG_BITS-1:0];
      case (idx)
        aws_pkg::REG_WINDOW_LENGTH: begin
          // window is frozen once the first sample is in
          if (!started)
            window_len = (w < 1) ? 1 : (w > WIN_MAX) ? WIN_MAX : w;
        end
        aws_pkg::REG_HYSTERESIS: hysteresis = data;
        default: ;
      endcase
    endfunction

    function longint unsigned saturate_add(longint unsigned acc, longint unsigned d);
      return (acc + d > ACC_MAX) ? ACC_MAX : acc + d;
    endfunction

    function void note_sample(logic signed [AW-1:0] alt);
      longint x;
      longint delta;
      longint q;
      stats_t e;
      x = alt;
      if (wr_ptr >= window_len) wr_ptr = 0;

      // drop the oldest sample once the ring is full, then add the new one
      if (held >= window_len) begin
        sum  = sum - ring[wr_ptr];
        held = window_len;
      end else begin
        held++;
      end
      ring[wr_ptr] = x;
      sum = sum + x;
      wr_ptr = (wr_ptr + 1 >= window_len) ? 0 : wr_ptr + 1;
      q = sum / held;

      if (!started || x < lowest) lowest = x;
      if (!started || x > highest) highest = x;

      // climb and drop count only past the hysteresis band
      if (!started) begin
        reference     = x;
        ascent_total  = 0;
        descent_total = 0;
      end
      delta = x - reference;
      if (delta > hysteresis) begin
        ascent_total = saturate_add(ascent_total, delta);
        reference    = x;
      end else if (-delta > hysteresis) begin
        descent_total = saturate_add(descent_total, -delta);
        reference     = x;
      end
      started = 1'b1;

      e.average = q[AW-1:0];
      e.minimum = lowest[AW-1:0];
      e.maximum = highest[AW-1:0];
      e.ascent  = ascent_total[31:0];
      e.descent = descent_total[31:0];
      pending.push_back(e);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        if (reports < REPORT_CAP) begin
          reports++;
          $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_summary(logic signed [AW-1:0] avg, logic signed [AW-1:0] mn,
                                logic signed [AW-1:0] mx, logic [31:0] up,
                                logic [31:0] down);
      stats_t e;
      if (pending.size() == 0) begin
        errors++;
        if (reports < REPORT_CAP) begin
          reports++;
          $display("%0t unexpected item: expected none, got average %0d", $time, avg);
        end
        return;
      end
      e = pending.pop_front();
      compare_field("average", e.average, avg);
      compare_field("minimum", e.minimum, mn);
      compare_field("maximum", e.maximum, mx);
      compare_field("ascent", e.ascent, up);
      compare_field("descent", e.descent, down);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [aws_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [aws_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [AW-1:0] in_altitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AW-1:0] out_average;
  logic signed [AW-1:0] out_minimum;
  logic signed [AW-1:0] out_maximum;
  logic [31:0] out_ascent;
  logic [31:0] out_descent;

  stats_tracker tracker = new();
  bit sender_idle_on = 1'b1;
  bit sink_stall_on = 1'b1;
  int stall_cycles_left = 0;
  int cycle_count = 0;

  altitude_window_statistics_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_altitude(in_altitude),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_average(out_average),
    .out_minimum(out_minimum),
    .out_maximum(out_maximum),
    .out_ascent (out_ascent),
    .out_descent(out_descent)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check each accepted result, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_summary(out_average, out_minimum, out_maximum, out_ascent, out_descent);
    if (!rst_n || !sink_stall_on) begin
      stall_cycles_left = 0;
      out_stall <= 1'b0;
    end else if (stall_cycles_left > 0) begin
      stall_cycles_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cycles_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [AW-1:0] clamp_altitude(longint v);
    if (v > ALT_TOP) v = ALT_TOP;
    if (v < ALT_BOTTOM) v = ALT_BOTTOM;
    return v[AW-1:0];
  endfunction

  // Write one register, then leave the port quiet before returning
  task automatic write_register(input logic [aws_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [aws_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.apply_register(idx, data);
    @(posedge clk);
  endtask

  // Offer one sample, maybe after an idle burst; valid stays high on return
  task automatic send_sample(input logic signed [AW-1:0] alt);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_altitude <= alt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_sample(alt);
  endtask

  // Hold off the sender until every result is back and the block is idle
  task automatic drain;
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int kind;
    int seg_len;
    int seg_count;
    int sent;
    int w;
    int h;
    logic [31:0] r;
    logic signed [AW-1:0] alt;
    longint walk;
    longint span;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Window is only writable before the first item: hit both clamps, then settle
    write_register(aws_pkg::REG_WINDOW_LENGTH, 16'd0);
    write_register(aws_pkg::REG_WINDOW_LENGTH, 16'd127);
    write_register(REG_SPARE_A, 16'hFFFF);
    r = $urandom();
    write_register(REG_SPARE_B, r[15:0]);
    case ($urandom_range(0, 3))
      0: w = 1;
      1: w = WIN_MAX;
      default: w = $urandom_range(2, WIN_MAX - 1);
    endcase
    r = $urandom();
    write_register(aws_pkg::REG_WINDOW_LENGTH, {r[15:7], w[6:0]});
    write_register(aws_pkg::REG_HYSTERESIS, 16'd1000);

    // Directed: first sample, extremes, edges of the hysteresis band
    send_sample(AW'(ALT_TOP));
    send_sample(AW'(ALT_BOTTOM));
    send_sample(AW'(-1));
    send_sample(AW'(0));
    send_sample(AW'(999));
    send_sample(AW'(1000));
    send_sample(AW'(0));
    send_sample(AW'(-1));
    drain;
    write_register(aws_pkg::REG_WINDOW_LENGTH, 16'd5);
    write_register(aws_pkg::REG_HYSTERESIS, 16'hFFFF);
    send_sample(AW'(65534));
    send_sample(AW'(65535));
    send_sample(AW'(0));
    send_sample(AW'(-1));
    drain;
    write_register(aws_pkg::REG_HYSTERESIS, 16'd0);
    send_sample(AW'(-1));
    send_sample(AW'(0));
    send_sample(AW'(-1));
    send_sample(AW'(ALT_TOP));
    send_sample(AW'(ALT_BOTTOM));

    // Random segments: uniform noise, climb/drop walks, band edges
    sent = 0;
    seg_count = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_count++;
      if (seg_count % 5 == 0) begin
        drain;
        case ($urandom_range(0, 3))
          0: h = 0;
          1: h = 65535;
          2: h = $urandom_range(0, 64);
          default: h = $urandom_range(0, 65535);
        endcase
        write_register(aws_pkg::REG_HYSTERESIS, h[15:0]);
      end
      sender_idle_on = ($urandom_range(0, 3) != 0);
      sink_stall_on  = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 2);
      seg_len = $urandom_range(10, 40);
      walk    = tracker.reference;
      repeat (seg_len) begin
        case (kind)
          0: begin
            r   = $urandom();
            alt = r[AW-1:0];
          end
          1: begin
            span = 2 * tracker.hysteresis + 3;
            walk = walk + longint'($urandom_range(0, span - 1)) - tracker.hysteresis - 1;
            alt  = clamp_altitude(walk);
            walk = alt;
          end
          default: begin
            case ($urandom_range(0, 5))
              0: alt = AW'(ALT_TOP);
              1: alt = AW'(ALT_BOTTOM);
              2: alt = clamp_altitude(tracker.reference + tracker.hysteresis);
              3: alt = clamp_altitude(tracker.reference + tracker.hysteresis + 1);
              4: alt = clamp_altitude(tracker.reference - tracker.hysteresis);
              default: alt = clamp_altitude(tracker.reference - tracker.hysteresis - 1);
            endcase
          end
        endcase
        send_sample(alt);
        sent++;
      end
    end

    // Full-scale swings with no hysteresis; no idling from here on
    drain;
    write_register(aws_pkg::REG_HYSTERESIS, 16'd0);
    sender_idle_on = 1'b0;
    sink_stall_on  = 1'b0;
    for (int i = 0; i < SWING_ITEMS; i++)
      send_sample((i % 2 == 0) ? AW'(ALT_TOP) : AW'(ALT_BOTTOM));
    repeat (40) begin
      r = $urandom();
      send_sample(r[AW-1:0]);
    end
    in_valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
